FILE: src/bac_pkg.sv
// Shared types, codes and constants of the bedtime alarm controller.
`default_nettype none
package bac_pkg;

    localparam int POT_BITS  = 10;
    localparam int TIME_BITS = 32;

    // Significant bits of t / 60 and of t / 3600.
    localparam int Q1_BITS = TIME_BITS - 5;
    localparam int Q2_BITS = TIME_BITS - 11;

    localparam int DIV_W     = 10;
    localparam int DIV_CNT_W = $clog2(TIME_BITS + 1);

    localparam int INC_W  = 6;
    localparam int STEP_W = 10;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_INC_PER_HOUR = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POT_STEP     = 4'd1;

    localparam logic [INC_W-1:0]  INC_RESET  = 6'd2;
    localparam logic [STEP_W-1:0] STEP_RESET = 10'd21;
    localparam logic [INC_W-1:0]  INC_MAX    = 6'd60;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ALARM  = 2'd1;
    localparam logic [1:0] MODE_EDIT   = 2'd2;

    localparam logic [DIV_W-1:0]  DIV_SIXTY   = 10'd60;
    localparam logic [DIV_W-1:0]  DIV_DAY_HRS = 10'd24;
    localparam logic [HOUR_W-1:0] HOUR_LAST   = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_PER_HR  = 6'd60;
    localparam logic [MIN_W-1:0]  MIN_LAST    = 6'd59;

    typedef struct packed {
        logic                 button_pressed;
        logic [POT_BITS-1:0]  pot_sample;
        logic                 time_valid;
        logic [TIME_BITS-1:0] local_time;
    } t_in;

    typedef struct packed {
        logic [1:0]        mode;
        logic              vibrate;
        logic [HOUR_W-1:0] alarm_hour;
        logic [MIN_W-1:0]  alarm_minute;
        logic [HOUR_W-1:0] clock_hour;
        logic [MIN_W-1:0]  clock_minute;
        logic [MIN_W-1:0]  clock_second;
        logic              alarm_fired;
    } t_out;

    // Minutes between alarm settings: 60 / inc for inc in 1..60.
    function automatic logic [MIN_W-1:0] min_per_step(input logic [INC_W-1:0] inc);
        logic [MIN_W-1:0] v;
        if (inc >= 6'd31)      v = 6'd1;
        else if (inc >= 6'd21) v = 6'd2;
        else if (inc >= 6'd16) v = 6'd3;
        else if (inc >= 6'd13) v = 6'd4;
        else if (inc >= 6'd11) v = 6'd5;
        else if (inc >= 6'd9)  v = 6'd6;
        else if (inc == 6'd8)  v = 6'd7;
        else if (inc == 6'd7)  v = 6'd8;
        else if (inc == 6'd6)  v = 6'd10;
        else if (inc == 6'd5)  v = 6'd12;
        else if (inc == 6'd4)  v = 6'd15;
        else if (inc == 6'd3)  v = 6'd20;
        else if (inc == 6'd2)  v = 6'd30;
        else                   v = 6'd60;
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: src/bedtime_alarm_controller.sv
// Top level of the bedtime alarm controller: sequencer, mode logic and ports.
// Sequencing: one shared bit-serial divider runs five divisions in turn (t/60, /60,
//   %24 over 32+27+21 bits, then pot/step and index/inc over 10 bits each).
// Requests: one in flight at a time; a new request stalls until the previous result is published.
// Reset: synchronous active low; clears mode, vibrate, alarm setting, last seen
//   time and the output valid, and loads inc_per_hour = 2, pot_step = 21.
`default_nettype none
module bedtime_alarm_controller (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire bac_pkg::t_in                   i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output bac_pkg::t_out                       o_out_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bac_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Sequencer states: one per division, then a slot to publish the result.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_T1   = 3'd1;   // t / 60 -> second
    localparam logic [2:0] S_T2   = 3'd2;   // (t/60) / 60 -> minute
    localparam logic [2:0] S_T3   = 3'd3;   // (t/3600) % 24 -> hour
    localparam logic [2:0] S_P1   = 3'd4;   // saturated pot / step -> index
    localparam logic [2:0] S_P2   = 3'd5;   // index / inc -> alarm hour, minute
    localparam logic [2:0] S_DONE = 3'd6;

    localparam int T_PAD1 = bac_pkg::TIME_BITS - bac_pkg::Q1_BITS;
    localparam int T_PAD2 = bac_pkg::TIME_BITS - bac_pkg::Q2_BITS;
    localparam int T_PADP = bac_pkg::TIME_BITS - bac_pkg::POT_BITS;

    // Configuration.
    logic [bac_pkg::INC_W-1:0]  r_inc;
    logic [bac_pkg::STEP_W-1:0] r_step;
    logic [bac_pkg::INC_W-1:0]  w_inc;
    logic [bac_pkg::STEP_W-1:0] w_step;

    // Sequencer and latched request.
    logic [2:0]    r_state;
    logic          r_go;
    bac_pkg::t_in  r_in;

    // Architectural state.
    logic [1:0]                     r_mode;
    logic                           r_vib;
    logic [bac_pkg::HOUR_W-1:0]     r_ahr;
    logic [bac_pkg::MIN_W-1:0]      r_amin;
    logic [bac_pkg::TIME_BITS-1:0]  r_last;

    // Partial results.
    logic [bac_pkg::Q1_BITS-1:0]  r_q1;
    logic [bac_pkg::Q2_BITS-1:0]  r_q2;
    logic [bac_pkg::MIN_W-1:0]    r_cs;
    logic [bac_pkg::MIN_W-1:0]    r_cm;
    logic [bac_pkg::HOUR_W-1:0]   r_ch;
    logic [bac_pkg::POT_BITS-1:0] r_idx;
    logic [bac_pkg::HOUR_W-1:0]   r_mhr;
    logic [bac_pkg::MIN_W-1:0]    r_mmn;

    // Output register.
    logic           r_out_valid;
    bac_pkg::t_out  r_out;

    // Divider hookup.
    logic [bac_pkg::TIME_BITS-1:0] w_dvd;
    logic [bac_pkg::DIV_CNT_W-1:0] w_bits;
    logic [bac_pkg::DIV_W-1:0]     w_dvs;
    logic                          w_done;
    logic [bac_pkg::TIME_BITS-1:0] w_quot;
    logic [bac_pkg::DIV_W-1:0]     w_rem;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_finish;
    logic [bac_pkg::POT_BITS-1:0]  w_pot_n;
    logic [bac_pkg::DIV_W-1:0]     w_half;
    logic                          w_round_up;
    logic [bac_pkg::MIN_W-1:0]     w_mps;
    logic [2*bac_pkg::MIN_W-1:0]   w_prod;
    logic [bac_pkg::POT_BITS-1:0]  w_map_hr;

    logic [1:0]                    n_mode;
    logic                          n_vib;
    logic [bac_pkg::HOUR_W-1:0]    n_ahr;
    logic [bac_pkg::MIN_W-1:0]     n_amin;
    logic [bac_pkg::TIME_BITS-1:0] n_last;
    logic                          n_fired;
    logic [bac_pkg::HOUR_W-1:0]    n_ch;
    logic [bac_pkg::MIN_W-1:0]     n_cm;
    logic [bac_pkg::MIN_W-1:0]     n_cs;

    assign o_cfg_ready = 1'b1;

    // Zero counts as 1; inc above 60 counts as 60.
    assign w_inc  = (r_inc == '0) ? bac_pkg::INC_W'(1) :
                    (r_inc > bac_pkg::INC_MAX) ? bac_pkg::INC_MAX : r_inc;
    assign w_step = (r_step == '0) ? bac_pkg::STEP_W'(1) : r_step;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_finish   = (r_state == S_DONE) && w_out_free;

    // Pot offset by one step, floored at 0.
    assign w_pot_n = (r_in.pot_sample >= w_step) ? (r_in.pot_sample - w_step) : '0;

    // Round to nearest, ties down: bump when the remainder beats its complement.
    assign w_half     = w_step - w_rem;
    assign w_round_up = (w_rem > w_half);

    assign w_mps    = bac_pkg::min_per_step(w_inc);
    assign w_prod   = w_rem[bac_pkg::MIN_W-1:0] * w_mps;
    assign w_map_hr = w_quot[bac_pkg::POT_BITS-1:0];

    // Steer the shared divider; operands sit left-aligned so only the
    // significant bits are shifted through.
    always_comb begin
        w_dvd  = '0;
        w_bits = '0;
        w_dvs  = bac_pkg::DIV_SIXTY;
        unique case (r_state)
            S_T1: begin
                w_dvd  = r_in.local_time;
                w_bits = bac_pkg::DIV_CNT_W'(bac_pkg::TIME_BITS);
            end
            S_T2: begin
                w_dvd  = {r_q1, {T_PAD1{1'b0}}};
                w_bits = bac_pkg::DIV_CNT_W'(bac_pkg::Q1_BITS);
            end
            S_T3: begin
                w_dvd  = {r_q2, {T_PAD2{1'b0}}};
                w_bits = bac_pkg::DIV_CNT_W'(bac_pkg::Q2_BITS);
                w_dvs  = bac_pkg::DIV_DAY_HRS;
            end
            S_P1: begin
                w_dvd  = {w_pot_n, {T_PADP{1'b0}}};
                w_bits = bac_pkg::DIV_CNT_W'(bac_pkg::POT_BITS);
                w_dvs  = w_step;
            end
            S_P2: begin
                w_dvd  = {r_idx, {T_PADP{1'b0}}};
                w_bits = bac_pkg::DIV_CNT_W'(bac_pkg::POT_BITS);
                w_dvs  = {{(bac_pkg::DIV_W - bac_pkg::INC_W){1'b0}}, w_inc};
            end
            default: begin
                w_dvd  = '0;
            end
        endcase
    end

    bac_sdiv #(
        .DW (bac_pkg::TIME_BITS),
        .VW (bac_pkg::DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go),
        .i_bits     (w_bits),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Mode step once all pieces are ready. The button acts first, then the
    // action of the mode reached runs in the same tick.
    always_comb begin
        n_mode  = r_mode;
        n_vib   = r_vib;
        n_ahr   = r_ahr;
        n_amin  = r_amin;
        n_last  = r_last;
        n_fired = 1'b0;
        n_ch    = r_in.time_valid ? r_ch : '0;
        n_cm    = r_in.time_valid ? r_cm : '0;
        n_cs    = r_in.time_valid ? r_cs : '0;

        if (r_in.button_pressed) begin
            unique case (r_mode)
                bac_pkg::MODE_ALARM: begin
                    n_mode = bac_pkg::MODE_NORMAL;
                    n_vib  = 1'b0;
                end
                bac_pkg::MODE_NORMAL: begin
                    n_mode = bac_pkg::MODE_EDIT;
                end
                default: begin
                    n_mode = bac_pkg::MODE_NORMAL;
                end
            endcase
        end

        priority if (n_mode == bac_pkg::MODE_NORMAL) begin
            // Check the alarm only on a fresh valid second.
            if (r_in.time_valid && (r_in.local_time != r_last)) begin
                if ((r_ch == r_ahr) && (r_cm == r_amin) && (r_cs == '0)) begin
                    n_mode  = bac_pkg::MODE_ALARM;
                    n_fired = 1'b1;
                end
                n_last = r_in.local_time;
            end
        end else if (n_mode == bac_pkg::MODE_ALARM) begin
            n_vib = !r_vib;
        end else begin
            n_ahr  = r_mhr;
            n_amin = r_mmn;
        end
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc       <= bac_pkg::INC_RESET;
            r_step      <= bac_pkg::STEP_RESET;
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_mode      <= bac_pkg::MODE_NORMAL;
            r_vib       <= 1'b0;
            r_ahr       <= '0;
            r_amin      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_go <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bac_pkg::CFG_INC_PER_HOUR) begin
                    r_inc <= i_cfg_data[bac_pkg::INC_W-1:0];
                end else if (i_cfg_index == bac_pkg::CFG_POT_STEP) begin
                    r_step <= i_cfg_data[bac_pkg::STEP_W-1:0];
                end
            end

            // Advance one division at a time.
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_T1;
                        r_go    <= 1'b1;
                    end
                end
                S_T1, S_T2, S_T3, S_P1: begin
                    if (w_done) begin
                        r_state <= r_state + 3'd1;
                        r_go    <= 1'b1;
                    end
                end
                S_P2: begin
                    if (w_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Commit the tick and hold the result until it is taken.
            if (w_finish) begin
                r_mode      <= n_mode;
                r_vib       <= n_vib;
                r_ahr       <= n_ahr;
                r_amin      <= n_amin;
                r_last      <= n_last;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: request latch, division results, output word.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end

        if (w_done) begin
            unique case (r_state)
                S_T1: begin
                    r_cs <= w_rem[bac_pkg::MIN_W-1:0];
                    r_q1 <= w_quot[bac_pkg::Q1_BITS-1:0];
                end
                S_T2: begin
                    r_cm <= w_rem[bac_pkg::MIN_W-1:0];
                    r_q2 <= w_quot[bac_pkg::Q2_BITS-1:0];
                end
                S_T3: begin
                    r_ch <= w_rem[bac_pkg::HOUR_W-1:0];
                end
                S_P1: begin
                    r_idx <= w_quot[bac_pkg::POT_BITS-1:0]
                             + {{(bac_pkg::POT_BITS-1){1'b0}}, w_round_up};
                end
                S_P2: begin
                    // Past the last hour: clamp to the last setting of the day.
                    if (w_map_hr > {{(bac_pkg::POT_BITS - bac_pkg::HOUR_W){1'b0}},
                                    bac_pkg::HOUR_LAST}) begin
                        r_mhr <= bac_pkg::HOUR_LAST;
                        r_mmn <= bac_pkg::MIN_PER_HR - w_mps;
                    end else begin
                        r_mhr <= w_map_hr[bac_pkg::HOUR_W-1:0];
                        r_mmn <= w_prod[bac_pkg::MIN_W-1:0];
                    end
                end
                default: begin
                    r_ch <= r_ch;
                end
            endcase
        end

        if (w_finish) begin
            r_out.mode         <= n_mode;
            r_out.vibrate      <= n_vib;
            r_out.alarm_hour   <= n_ahr;
            r_out.alarm_minute <= n_amin;
            r_out.clock_hour   <= n_ch;
            r_out.clock_minute <= n_cm;
            r_out.clock_second <= n_cs;
            r_out.alarm_fired  <= n_fired;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: src/bac_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
`default_nettype none
module bac_sdiv #(
    parameter  int DW = 32,
    parameter  int VW = 10,
    localparam int CW = $clog2(DW + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [CW-1:0] i_bits,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quot,
    output logic [VW-1:0]      o_rem
);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW-1:0] r_sh;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;

    logic [VW:0]   w_trial;
    logic [VW:0]   w_diff;
    logic          w_qbit;

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    assign w_trial = {r_rem, r_sh[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_qbit  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= i_bits;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_sh  <= {r_sh[DW-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[VW-1:0] : w_trial[VW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

FILE: src/bac_chk.sv
// Port-level assertions for the bedtime alarm controller, bound to the top.
`default_nettype none
module bac_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire bac_pkg::t_out o_out_data
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // Drop the output valid during reset.
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid survived reset");

    // A fired alarm always leaves the block ringing.
    a_fired_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.alarm_fired |-> o_out_data.mode == bac_pkg::MODE_ALARM)
        else $error("alarm fired outside alarm mode");

    // The motor runs only while ringing.
    a_vib_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.mode != bac_pkg::MODE_ALARM |-> !o_out_data.vibrate)
        else $error("vibrate high outside alarm mode");

    // The alarm setting stays a time of day.
    a_alarm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.alarm_hour <= bac_pkg::HOUR_LAST)
                        && (o_out_data.alarm_minute <= bac_pkg::MIN_LAST))
        else $error("alarm setting out of range");

endmodule

bind bedtime_alarm_controller bac_chk u_bac_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

FILE: test/alarm_tick_checker.sv
`timescale 1ns / 100ps
// Tick checker: predicts every alarm controller result from accepted requests and compares.
module alarm_tick_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  bac_pkg::t_in                   i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  bac_pkg::t_out                  i_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [bac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam int REPORT_LIMIT  = 10;
    localparam int SECS_PER_MIN  = 60;
    localparam int SECS_PER_HOUR = 3600;
    localparam int HOURS_PER_DAY = 24;
    localparam int MINS_PER_HOUR = 60;
    localparam int LAST_HOUR     = 23;

    // Shadow of the controller's registers and state.
    logic [bac_pkg::INC_W-1:0]  cfg_inc;
    logic [bac_pkg::STEP_W-1:0] cfg_step;
    logic [1:0]                 mode_now;
    logic                       vibrating;
    int unsigned                alarm_hour_set;
    int unsigned                alarm_min_set;
    longint unsigned            last_secs;

    bac_pkg::t_out expected_ticks[$];
    int            fail_total = 0;

    function automatic string describe_tick(input bac_pkg::t_out r);
        return $sformatf("mode=%0d vib=%0d alarm=%0d:%0d clock=%0d:%0d:%0d fired=%0d",
                         r.mode, r.vibrate, r.alarm_hour, r.alarm_minute,
                         r.clock_hour, r.clock_minute, r.clock_second, r.alarm_fired);
    endfunction

    // Advance the shadow state by one tick and return the result it produces.
    function automatic bac_pkg::t_out predict_tick(input bac_pkg::t_in req);
        bac_pkg::t_out   res;
        longint unsigned secs;
        int unsigned     hh, mm, ss, inc, stp, n, q, r, idx;
        logic            fired;
        secs  = 64'(req.local_time);
        hh    = 0;
        mm    = 0;
        ss    = 0;
        fired = 1'b0;
        if (req.time_valid) begin
            hh = 32'((secs / SECS_PER_HOUR) % HOURS_PER_DAY);
            mm = 32'((secs / SECS_PER_MIN) % MINS_PER_HOUR);
            ss = 32'(secs % SECS_PER_MIN);
        end

        if (req.button_pressed) begin
            case (mode_now)
                bac_pkg::MODE_ALARM: begin
                    mode_now  = bac_pkg::MODE_NORMAL;
                    vibrating = 1'b0;
                end
                bac_pkg::MODE_NORMAL: mode_now = bac_pkg::MODE_EDIT;
                default:              mode_now = bac_pkg::MODE_NORMAL;
            endcase
        end

        case (mode_now)
            bac_pkg::MODE_NORMAL: begin
                if (req.time_valid && secs != last_secs) begin
                    if (hh == alarm_hour_set && mm == alarm_min_set && ss == 0) begin
                        mode_now = bac_pkg::MODE_ALARM;
                        fired    = 1'b1;
                    end
                    last_secs = secs;
                end
            end
            bac_pkg::MODE_ALARM: vibrating = ~vibrating;
            default: begin
                // Pot to step index, rounding ties down, then to hour and minute.
                inc = (cfg_inc == 0) ? 1 :
                      ((cfg_inc > bac_pkg::INC_MAX) ? bac_pkg::INC_MAX : cfg_inc);
                stp = (cfg_step == 0) ? 1 : cfg_step;
                n   = (req.pot_sample >= stp) ? req.pot_sample - stp : 0;
                q   = n / stp;
                r   = n % stp;
                idx = q + ((r > stp - r) ? 1 : 0);
                alarm_hour_set = idx / inc;
                alarm_min_set  = (idx % inc) * (MINS_PER_HOUR / inc);
                if (alarm_hour_set > LAST_HOUR) begin
                    alarm_hour_set = LAST_HOUR;
                    alarm_min_set  = MINS_PER_HOUR - MINS_PER_HOUR / inc;
                end
            end
        endcase

        res.mode         = mode_now;
        res.vibrate      = vibrating;
        res.alarm_hour   = bac_pkg::HOUR_W'(alarm_hour_set);
        res.alarm_minute = bac_pkg::MIN_W'(alarm_min_set);
        res.clock_hour   = bac_pkg::HOUR_W'(hh);
        res.clock_minute = bac_pkg::MIN_W'(mm);
        res.clock_second = bac_pkg::MIN_W'(ss);
        res.alarm_fired  = fired;
        return res;
    endfunction

    always @(posedge i_clk) begin : track
        bac_pkg::t_out want;
        if (!i_rst_n) begin
            cfg_inc        = bac_pkg::INC_RESET;
            cfg_step       = bac_pkg::STEP_RESET;
            mode_now       = bac_pkg::MODE_NORMAL;
            vibrating      = 1'b0;
            alarm_hour_set = 0;
            alarm_min_set  = 0;
            last_secs      = 0;
            expected_ticks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    bac_pkg::CFG_INC_PER_HOUR: cfg_inc = i_cfg_data[bac_pkg::INC_W-1:0];
                    bac_pkg::CFG_POT_STEP:     cfg_step = i_cfg_data[bac_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
            // Compare before queuing, so a request accepted on this edge is not matched.
            if (i_out_valid && !i_out_stall) begin
                if (expected_ticks.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("unexpected result: %s", describe_tick(i_out_data));
                end else begin
                    want = expected_ticks.pop_front();
                    if (i_out_data.mode !== want.mode ||
                        i_out_data.vibrate !== want.vibrate ||
                        i_out_data.alarm_hour !== want.alarm_hour ||
                        i_out_data.alarm_minute !== want.alarm_minute ||
                        i_out_data.clock_hour !== want.clock_hour ||
                        i_out_data.clock_minute !== want.clock_minute ||
                        i_out_data.clock_second !== want.clock_second ||
                        i_out_data.alarm_fired !== want.alarm_fired) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                            $display("result mismatch: expected %s, got %s",
                                     describe_tick(want), describe_tick(i_out_data));
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_ticks.push_back(predict_tick(i_in_data));
        end
        o_pending    = expected_ticks.size();
        o_fail_count = fail_total;
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Testbench top: drives ticks and register writes into the alarm controller and reports.
module testbench;

    // The slowest correct run is about 1600 requests plus the long hold-offs;
    // the limit allows several times its length.
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int PHASE_COUNT     = 10;
    localparam int TICKS_PER_PHASE = 150;
    localparam int LONG_HOLD       = 500;
    localparam int DRAIN_CYCLES    = 150;
    localparam int SECS_PER_MIN    = 60;
    localparam int SECS_PER_HOUR   = 3600;
    localparam int SECS_PER_DAY    = 86400;
    localparam int LAST_DAY        = 49000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    bac_pkg::t_in                   i_in_data;
    logic                           o_out_valid;
    logic                           i_out_stall;
    bac_pkg::t_out                  o_out_data;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [bac_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bac_pkg::CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending_ticks;
    int cycle_count = 0;

    // quiet: no gaps on either side; long_hold_req: receiver holds off once.
    bit quiet         = 1'b0;
    bit long_hold_req = 1'b0;

    // Latest mode and alarm setting seen on the output, used to steer stimulus.
    logic [1:0]                 seen_mode         = bac_pkg::MODE_NORMAL;
    logic [bac_pkg::HOUR_W-1:0] seen_alarm_hour   = '0;
    logic [bac_pkg::MIN_W-1:0]  seen_alarm_minute = '0;

    bedtime_alarm_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    alarm_tick_checker tick_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_ticks)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort on a hang.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            seen_mode         <= o_out_data.mode;
            seen_alarm_hour   <= o_out_data.alarm_hour;
            seen_alarm_minute <= o_out_data.alarm_minute;
        end
    end

    // Offer one tick request after a random gap and hold it until accepted.
    // Called at a falling edge; returns at the falling edge after acceptance with
    // valid still high, so a back-to-back request never drops it.
    task automatic offer_tick(input logic pressed,
                              input logic [bac_pkg::POT_BITS-1:0] pot,
                              input logic valid,
                              input logic [bac_pkg::TIME_BITS-1:0] secs);
        int           gap;
        bac_pkg::t_in req;
        gap                = quiet ? 0 : $urandom_range(0, 9);
        req.button_pressed = pressed;
        req.pot_sample     = pot;
        req.time_valid     = valid;
        req.local_time     = secs;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  <= req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write one register; valid stays high so writes can follow back to back.
    task automatic put_reg(input logic [bac_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bac_pkg::CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Result side: draw a stall before each result, with one long hold-off on
    // request so the block fills up and back-pressures the sender.
    initial begin : result_receiver
        int hold;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold          = LONG_HOLD;
            end else begin
                hold = quiet ? 0 : $urandom_range(0, 9);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        logic [bac_pkg::CFG_DATA_W-1:0] inc_data;
        logic [bac_pkg::CFG_DATA_W-1:0] step_data;
        logic [bac_pkg::TIME_BITS-1:0]  clock_secs;
        logic [bac_pkg::TIME_BITS-1:0]  secs;
        logic [bac_pkg::POT_BITS-1:0]   pot;
        logic                           pressed;
        logic                           valid;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        clock_secs  = $urandom();

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks at reset settings (one alarm per half hour, step 21).
        offer_tick(1'b0, 10'd0,    1'b0, 32'hFFFF_FFFF);     // time not valid
        offer_tick(1'b0, 10'd1023, 1'b1, 32'd0);             // equals last seen: no alarm
        offer_tick(1'b0, 10'd0,    1'b1, 32'd86400);         // midnight: alarm fires
        offer_tick(1'b0, 10'd0,    1'b1, 32'd86400);         // ringing: vibrate toggles
        offer_tick(1'b0, 10'd0,    1'b1, 32'd86401);
        offer_tick(1'b1, 10'd0,    1'b1, 32'd86401);         // press: back to normal
        offer_tick(1'b1, 10'd0,    1'b1, 32'd86402);         // press: edit, pot at zero
        offer_tick(1'b0, 10'd1023, 1'b1, 32'd86402);         // pot at top: clamp to 23
        offer_tick(1'b0, 10'd31,   1'b1, 32'd86403);         // rounds down
        offer_tick(1'b0, 10'd32,   1'b1, 32'd86403);         // rounds up: 0:30
        offer_tick(1'b1, 10'd1023, 1'b0, 32'd0);             // back to normal
        offer_tick(1'b0, 10'd0,    1'b1, 32'd88200);         // 0:30:00 fires
        offer_tick(1'b1, 10'd0,    1'b1, 32'd88200);         // stop, same second: no refire
        offer_tick(1'b0, 10'd0,    1'b1, 32'd174600);        // next day 0:30:00 fires
        offer_tick(1'b1, 10'd0,    1'b1, 32'd174601);
        offer_tick(1'b0, 10'd0,    1'b0, 32'd261000);        // matching time, not valid
        offer_tick(1'b0, 10'd0,    1'b1, 32'hFFFF_FFFF);     // largest time
        offer_tick(1'b1, 10'd21,   1'b1, 32'hFFFF_FFFF);     // edit, pot equal to step
        offer_tick(1'b0, 10'd20,   1'b1, 32'd5);             // pot below step saturates
        offer_tick(1'b1, 10'd512,  1'b1, 32'd6);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase > 0) begin
                // Drain, then reprogram while the block is idle.
                i_in_valid <= 1'b0;
                while (pending_ticks != 0) @(negedge i_clk);
                case (phase)
                    1: begin inc_data = 10'd1;    step_data = 10'd1;    end
                    2: begin inc_data = 10'd60;   step_data = 10'd1023; end
                    3: begin inc_data = 10'd0;    step_data = 10'd0;    end
                    4: begin inc_data = 10'h3FF;  step_data = 10'd1022; end
                    5: begin inc_data = 10'd7;    step_data = 10'd2;    end
                    6: begin inc_data = 10'd3;    step_data = 10'd50;   end
                    7: begin inc_data = 10'd12;   step_data = 10'd4;    end
                    default: begin
                        inc_data  = bac_pkg::CFG_DATA_W'($urandom());
                        step_data = bac_pkg::CFG_DATA_W'($urandom());
                    end
                endcase
                // An index past the last register must be ignored.
                put_reg(bac_pkg::CFG_IDX_W'(bac_pkg::CFG_POT_STEP + 1
                            + $urandom_range(0, (1 << bac_pkg::CFG_IDX_W) - 3)),
                        bac_pkg::CFG_DATA_W'($urandom()));
                put_reg(bac_pkg::CFG_INC_PER_HOUR, inc_data);
                put_reg(bac_pkg::CFG_POT_STEP, step_data);
                i_cfg_valid <= 1'b0;
            end
            quiet = (phase == 2 || phase == 6);
            if (phase == 4)
                long_hold_req = 1'b1;

            for (int k = 0; k < TICKS_PER_PHASE; k++) begin
                if ($urandom_range(0, 5) == 0) begin
                    // Noise: any field value at all.
                    pressed = 1'($urandom_range(0, 1));
                    pot     = bac_pkg::POT_BITS'($urandom());
                    valid   = 1'($urandom_range(0, 1));
                    secs    = $urandom();
                end else begin
                    // Plausible use: time creeps at half-second ticks, sometimes
                    // jumps to just before the alarm; presses leave edit and
                    // ringing sooner than they leave normal.
                    if (seen_mode == bac_pkg::MODE_NORMAL)
                        pressed = ($urandom_range(0, 24) == 0);
                    else
                        pressed = ($urandom_range(0, 3) == 0);
                    if ($urandom_range(0, 19) == 0)
                        clock_secs = bac_pkg::TIME_BITS'($urandom_range(0, LAST_DAY))
                                       * SECS_PER_DAY
                                   + seen_alarm_hour * SECS_PER_HOUR
                                   + seen_alarm_minute * SECS_PER_MIN
                                   - $urandom_range(0, 3);
                    else
                        clock_secs = clock_secs + $urandom_range(0, 1);
                    pot   = bac_pkg::POT_BITS'($urandom());
                    valid = ($urandom_range(0, 19) != 0);
                    secs  = clock_secs;
                end
                offer_tick(pressed, pot, valid, secs);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_ticks != 0) @(negedge i_clk);
        // Give a stray extra result time to show up.
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
